FILE: rtl/nns_pkg.sv
package nns_pkg;

	localparam int DIM         = 128;
	localparam int MAX_VECTORS = 65536;

	localparam int POS_W   = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int IDX_W   = $clog2(MAX_VECTORS);
	localparam int VC_W    = IDX_W + 1;
	localparam int COORD_W = 16;
	localparam int ABS_W   = 16;
	localparam int SQ_W    = 2 * ABS_W;
	localparam int SUM_W   = 39;
	localparam int ROOT_W  = 20;
	localparam int INDEX_W = 16;

	localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
	localparam logic [ROOT_W-1:0] ROOT_ONES = {ROOT_W{1'b1}};

	// strobes from the sequencer into the distance datapath
	typedef struct packed {
		logic mul_en;
		logic acc_en;
		logic last_vec;
		logic last_set;
	} dist_ctrl_t;

	// search state as it stands after the current accumulate step
	typedef struct packed {
		logic             found;
		logic [SUM_W-1:0] best_sum;
		logic [IDX_W-1:0] best_pos;
	} dist_res_t;

endpackage

FILE: rtl/nns_qmem.sv
module nns_qmem (
	input  logic                                clk,
	input  logic                                wr_en,
	input  logic [nns_pkg::POS_W-1:0]           wr_addr,
	input  logic signed [nns_pkg::COORD_W-1:0]  wr_data,
	input  logic                                rd_en,
	input  logic [nns_pkg::POS_W-1:0]           rd_addr,
	output logic signed [nns_pkg::COORD_W-1:0]  rd_data
);

	logic signed [nns_pkg::COORD_W-1:0] mem [nns_pkg::DIM];
	logic signed [nns_pkg::COORD_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/nns_dist.sv
module nns_dist (
	input  logic                                clk,
	input  logic                                arst_n,
	input  nns_pkg::dist_ctrl_t                 ctrl,
	input  logic signed [nns_pkg::COORD_W-1:0]  coord,
	input  logic signed [nns_pkg::COORD_W-1:0]  query,
	output nns_pkg::dist_res_t                  res
);

	logic signed [nns_pkg::COORD_W:0]   diff;
	logic signed [nns_pkg::COORD_W:0]   neg_diff;
	logic [nns_pkg::ABS_W-1:0]          abs_diff;
	logic [nns_pkg::SQ_W-1:0]           sq_s1;
	logic [nns_pkg::SUM_W:0]            sum_wide;
	logic [nns_pkg::SUM_W-1:0]          new_sum;
	logic                               cnt_ok;
	logic                               take;

	logic [nns_pkg::SUM_W-1:0]          run_q;
	logic [nns_pkg::SUM_W-1:0]          best_q;
	logic [nns_pkg::IDX_W-1:0]          best_pos_q;
	logic [nns_pkg::VC_W-1:0]           vc_q;
	logic                               found_q;

	assign diff     = {coord[nns_pkg::COORD_W-1], coord} - {query[nns_pkg::COORD_W-1], query};
	assign neg_diff = -diff;
	assign abs_diff = diff[nns_pkg::COORD_W] ? neg_diff[nns_pkg::ABS_W-1:0]
	                                         : diff[nns_pkg::ABS_W-1:0];

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			sq_s1 <= abs_diff * abs_diff;
		end
	end

	// saturating accumulate, then the compare against the best so far
	assign sum_wide = {1'b0, run_q} + (nns_pkg::SUM_W+1)'(sq_s1);
	assign new_sum  = sum_wide[nns_pkg::SUM_W] ? nns_pkg::SUM_MAX
	                                           : sum_wide[nns_pkg::SUM_W-1:0];
	assign cnt_ok   = vc_q < nns_pkg::VC_W'(nns_pkg::MAX_VECTORS);
	assign take     = ctrl.last_vec && cnt_ok && (!found_q || new_sum < best_q);

	assign res.found    = found_q || (ctrl.last_vec && cnt_ok);
	assign res.best_sum = take ? new_sum : best_q;
	assign res.best_pos = take ? vc_q[nns_pkg::IDX_W-1:0] : best_pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= '0;
			best_q     <= nns_pkg::SUM_MAX;
			best_pos_q <= '0;
			vc_q       <= '0;
			found_q    <= 1'b0;
		end else if (ctrl.acc_en) begin
			if (ctrl.last_set) begin
				run_q      <= '0;
				best_q     <= nns_pkg::SUM_MAX;
				best_pos_q <= '0;
				vc_q       <= '0;
				found_q    <= 1'b0;
			end else begin
				run_q      <= ctrl.last_vec ? '0 : new_sum;
				best_q     <= res.best_sum;
				best_pos_q <= res.best_pos;
				found_q    <= res.found;
				if (ctrl.last_vec && cnt_ok) begin
					vc_q <= vc_q + 1'b1;
				end
			end
		end
	end

endmodule

FILE: rtl/nns_sqrt.sv
module nns_sqrt (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [nns_pkg::SUM_W-1:0]          value,
	output logic                               busy,
	output logic                               done,
	output logic [nns_pkg::ROOT_W-1:0]         root
);

	localparam int RAD_W  = 2 * nns_pkg::ROOT_W;
	localparam int REM_W  = nns_pkg::ROOT_W + 2;
	localparam int CNT_W  = $clog2(nns_pkg::ROOT_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(nns_pkg::ROOT_W - 1);

	logic [RAD_W-1:0]            rad_q;
	logic [REM_W-1:0]            rem_q;
	logic [nns_pkg::ROOT_W-1:0]  root_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic [REM_W+1:0]            rem_sh;
	logic [REM_W+1:0]            trial;
	logic                        fits;
	logic [REM_W+1:0]            rem_sub;

	// one result bit per cycle, two radicand bits brought down each step
	assign rem_sh  = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign fits    = rem_sh >= trial;
	assign rem_sub = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= RAD_W'(value);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
			root_q <= {root_q[nns_pkg::ROOT_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q;

endmodule

FILE: rtl/nearest_neighbor_search_core.sv
// Brute-force nearest neighbor search over squared Euclidean distance. Beats with func low
// load the query one coordinate at a time into a DIM-entry memory without stalling the
// input. Beats with func high carry candidate coordinates and run in order through the
// query memory read, the shared 16x16 square of the difference, and the saturating
// accumulate and best-so-far compare. The beat marked last_of_set then starts the square
// root, a shared iterative unit giving one result bit per cycle, and the result is
// registered once the root is done; in_stall stays high while any of this runs. A result
// waiting on out_stall holds up new input beats only once the next set's root is done,
// keeping in_stall high until the waiting result is taken. The query is kept across sets;
// reading a query coordinate that was never loaded gives an undefined distance.
module nearest_neighbor_search_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                func,
	input  logic signed [nns_pkg::COORD_W-1:0]  coordinate,
	input  logic                                last_of_vector,
	input  logic                                last_of_set,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [nns_pkg::ROOT_W-1:0]          min_distance,
	output logic [nns_pkg::SUM_W-1:0]           min_sq_distance,
	output logic [nns_pkg::INDEX_W-1:0]         nearest_index,
	output logic                                empty_set
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_ACC  = 4'b0100,
		S_ROOT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	logic                                in_acc;
	logic [nns_pkg::POS_W-1:0]           pos_q;
	logic [nns_pkg::POS_W:0]             pos_inc;
	logic                                pos_wrap;
	logic signed [nns_pkg::COORD_W-1:0]  coord_q;
	logic                                lv_q;
	logic                                ls_q;
	logic signed [nns_pkg::COORD_W-1:0]  query;

	nns_pkg::dist_ctrl_t                 ctrl;
	nns_pkg::dist_res_t                  res;

	logic                                sq_start;
	logic                                sq_busy;
	logic                                sq_done;
	logic [nns_pkg::ROOT_W-1:0]          sq_root;

	logic                                res_empty_q;
	logic [nns_pkg::SUM_W-1:0]           res_sq_q;
	logic [nns_pkg::IDX_W-1:0]           res_idx_q;
	logic [31:0]                         idx_wide;

	logic                                out_load;
	logic                                out_valid_q;
	logic [nns_pkg::ROOT_W-1:0]          out_dist_q;
	logic [nns_pkg::SUM_W-1:0]           out_sq_q;
	logic [nns_pkg::INDEX_W-1:0]         out_idx_q;
	logic                                out_empty_q;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && (state_q == S_IDLE);

	assign pos_inc  = {1'b0, pos_q} + 1'b1;
	assign pos_wrap = (pos_inc == (nns_pkg::POS_W+1)'(nns_pkg::DIM));

	nns_qmem u_qmem (
		.clk     (clk),
		.wr_en   (in_acc && !func),
		.wr_addr (pos_q),
		.wr_data (coordinate),
		.rd_en   (in_acc && func),
		.rd_addr (pos_q),
		.rd_data (query)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			coord_q <= coordinate;
			lv_q    <= last_of_vector;
			ls_q    <= last_of_set;
		end
	end

	// query loading and candidate streaming share the coordinate position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_acc && !func) begin
			pos_q <= (last_of_vector || pos_wrap) ? '0 : pos_inc[nns_pkg::POS_W-1:0];
		end else if (state_q == S_ACC) begin
			pos_q <= (lv_q || ls_q || pos_wrap) ? '0 : pos_inc[nns_pkg::POS_W-1:0];
		end
	end

	assign ctrl.mul_en   = (state_q == S_MUL);
	assign ctrl.acc_en   = (state_q == S_ACC);
	assign ctrl.last_vec = lv_q || ls_q || pos_wrap;
	assign ctrl.last_set = ls_q;

	nns_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.coord  (coord_q),
		.query  (query),
		.res    (res)
	);

	assign sq_start = (state_q == S_ACC) && ls_q;

	nns_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (res.best_sum),
		.busy   (sq_busy),
		.done   (sq_done),
		.root   (sq_root)
	);

	always_ff @(posedge clk) begin
		if (sq_start) begin
			res_empty_q <= !res.found;
			res_sq_q    <= res.best_sum;
			res_idx_q   <= res.best_pos;
		end
	end

	assign idx_wide = 32'(res_idx_q);
	assign out_load = (state_q == S_ROOT) && sq_done && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc && func) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				state_d = S_ACC;
			end
			S_ACC: begin
				state_d = ls_q ? S_ROOT : S_IDLE;
			end
			S_ROOT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_dist_q  <= res_empty_q ? nns_pkg::ROOT_ONES : sq_root;
			out_sq_q    <= res_empty_q ? nns_pkg::SUM_MAX : res_sq_q;
			out_idx_q   <= res_empty_q ? '0 : idx_wide[nns_pkg::INDEX_W-1:0];
			out_empty_q <= res_empty_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign min_distance    = out_dist_q;
	assign min_sq_distance = out_sq_q;
	assign nearest_index   = out_idx_q;
	assign empty_set       = out_empty_q;

	a_cand_seq: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func |=> state_q == S_MUL ##1 state_q == S_ACC)
		else $error("candidate beat did not run read, square and accumulate in order");

	a_sqrt_free: assert property (@(posedge clk) disable iff (!arst_n)
		sq_start |-> !sq_busy)
		else $error("square root started while still busy");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_set |-> min_sq_distance == nns_pkg::SUM_MAX &&
			min_distance == nns_pkg::ROOT_ONES && nearest_index == '0)
		else $error("empty-set result carries wrong distance or index");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) < nns_pkg::DIM)
		else $error("coordinate position out of range");

endmodule
